// ===== rtl/cubic_trajectory_interpolator_assert.svh =====
// Assertion macros for the cubic trajectory interpolator.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef CUBIC_TRAJECTORY_INTERPOLATOR_ASSERT_SVH
`define CUBIC_TRAJECTORY_INTERPOLATOR_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define CTI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define CTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cti_pkg.sv =====
// Shared types, constants and helpers of the cubic trajectory interpolator.
// Depends on nothing; every other file but the assertion macro header imports it.
package cti_pkg;

	localparam int TIME_BITS  = 20;
	localparam int POS_BITS   = 32;
	localparam int QUAT_BITS  = 16;
	localparam int FRAC_Q     = 30;
	localparam int UQ_BITS    = FRAC_Q + 1;
	localparam int MUL_A_BITS = POS_BITS;
	localparam int MUL_B_BITS = UQ_BITS;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
	localparam int DIVQ_BITS  = POS_BITS + 2;
	localparam int CNT_BITS   = 6;
	localparam int SAT_BITS   = POS_BITS + 4;

	localparam logic [UQ_BITS-1:0] ONE_Q = UQ_BITS'(1) << FRAC_Q;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam logic [CNT_BITS-1:0] U_STEPS = CNT_BITS'(FRAC_Q);
	localparam logic [CNT_BITS-1:0] V_STEPS = CNT_BITS'(DIVQ_BITS);
	localparam logic KIND_MOVE = 1'b0;
	localparam logic KIND_REF  = 1'b1;

	typedef enum logic [1:0] {
		MODE_TICK,
		MODE_FEEDBACK,
		MODE_MOVE,
		MODE_PUBLISH
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOVE_RSP,
		S_UDIV_GO,
		S_UDIV,
		S_M_UU,
		S_M_U2U,
		S_M_W,
		S_W_GET,
		S_AX_P,
		S_AX_V,
		S_AX_VGO,
		S_AX_VDIV,
		S_PUB_OUT
	} cti_state_t;

	typedef struct packed {
		mode_t                        mode;
		logic signed [POS_BITS-1:0]   coord_x;
		logic signed [POS_BITS-1:0]   coord_y;
		logic signed [POS_BITS-1:0]   coord_z;
		logic [TIME_BITS-1:0]         move_duration;
		logic signed [QUAT_BITS-1:0]  quat_w;
		logic signed [QUAT_BITS-1:0]  quat_x;
		logic signed [QUAT_BITS-1:0]  quat_y;
		logic signed [QUAT_BITS-1:0]  quat_z;
	} cti_in_t;

	typedef struct packed {
		logic                         kind;
		logic                         accepted;
		logic signed [POS_BITS-1:0]   ref_x;
		logic signed [POS_BITS-1:0]   ref_y;
		logic signed [POS_BITS-1:0]   ref_z;
		logic signed [POS_BITS-1:0]   vel_x;
		logic signed [POS_BITS-1:0]   vel_y;
		logic signed [POS_BITS-1:0]   vel_z;
		logic signed [QUAT_BITS-1:0]  out_qw;
		logic signed [QUAT_BITS-1:0]  out_qx;
		logic signed [QUAT_BITS-1:0]  out_qy;
		logic signed [QUAT_BITS-1:0]  out_qz;
	} cti_out_t;

	typedef struct packed {
		logic                   start;
		logic [TIME_BITS-1:0]   rem_init;
		logic                   q_init;
		logic [DIVQ_BITS-1:0]   dividend;
		logic [CNT_BITS-1:0]    steps;
		logic [TIME_BITS-1:0]   divisor;
	} cti_div_req_t;

	function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SAT_BITS-1:0] v);
		logic signed [SAT_BITS-1:0] hi;
		logic signed [SAT_BITS-1:0] lo;
		hi = SAT_BITS'({1'b0, {(POS_BITS-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return hi[POS_BITS-1:0];
		end else if (v < lo) begin
			return lo[POS_BITS-1:0];
		end
		return v[POS_BITS-1:0];
	endfunction

endpackage

// ===== rtl/cti_mul.sv =====
// Shared unsigned multiplier of the interpolator with a registered product.
// Depends on cti_pkg for the operand widths.
module cti_mul import cti_pkg::*; (
	input  logic                   clk,
	input  logic [MUL_A_BITS-1:0]  a,
	input  logic [MUL_B_BITS-1:0]  b,
	output logic [PROD_BITS-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(a) * PROD_BITS'(b);
	end

endmodule

// ===== rtl/cti_div.sv =====
// Bit-serial restoring divider of the interpolator, one quotient bit per cycle.
// Depends on cti_pkg for the request type and widths.
module cti_div import cti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cti_div_req_t          req,
	output logic                  done,
	output logic [DIVQ_BITS-1:0]  quotient
);

	logic [TIME_BITS-1:0]  rem_q;
	logic [DIVQ_BITS-1:0]  quo_q;
	logic [DIVQ_BITS-1:0]  sh_q;
	logic [TIME_BITS-1:0]  div_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  done_q;
	logic [TIME_BITS:0]    trial;
	logic [TIME_BITS:0]    diff;
	logic                  ge;

	assign trial = {rem_q, sh_q[DIVQ_BITS-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_BITS'(1);
			done_q <= cnt_q == CNT_BITS'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			quo_q <= DIVQ_BITS'(req.q_init);
			sh_q  <= req.dividend;
			div_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			quo_q <= {quo_q[DIVQ_BITS-2:0], ge};
			sh_q  <= sh_q << 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/cubic_trajectory_interpolator.sv =====
// Three-axis rest-to-rest cubic trajectory planner with a sequenced shared datapath.
// Depends on cti_pkg, cti_mul, cti_div and the assertion macro header.
// Tick and pose feedback words are taken while idle and give no result; a move command
// gives its response through the S_MOVE_RSP state once the output register is free. For a
// publish word one bit-serial divider forms u = t/T and then each axis's velocity, and a
// single registered multiplier serves u^2, u^3, u(1-u) and both products of each axis. The
// input is not ready while a move or publish word is being worked on; the result waits in
// an output register so that the next word can be taken meanwhile.
`include "cubic_trajectory_interpolator_assert.svh"

module cubic_trajectory_interpolator import cti_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  cti_in_t   req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output cti_out_t  rsp
);

	cti_state_t state_q, state_d;

	logic [TIME_BITS-1:0]        elapsed_q;
	logic [TIME_BITS-1:0]        sampled_q;
	logic [TIME_BITS-1:0]        duration_q;
	logic signed [POS_BITS-1:0]  fb_q [3];
	logic signed [POS_BITS-1:0]  start_q [3];
	logic signed [POS_BITS-1:0]  target_q [3];
	logic signed [QUAT_BITS-1:0] orient_q [4];
	logic                        move_ok_q;
	logic [UQ_BITS-1:0]          u_q, u2_q, s_q, w_q;
	logic [1:0]                  axis_q;
	logic signed [POS_BITS-1:0]  ref_q [3];
	logic signed [POS_BITS-1:0]  vel_q [3];
	logic                        rsp_valid_q;
	cti_out_t                    rsp_q;

	logic                        acc_in;
	logic                        move_ok;
	logic [TIME_BITS-1:0]        dur_eff, t_eff;
	logic [MUL_A_BITS-1:0]       mul_a;
	logic [MUL_B_BITS-1:0]       mul_b;
	logic [PROD_BITS-1:0]        prod_q;
	logic [PROD_BITS-1:0]        prod_rnd;
	logic [POS_BITS:0]           prod_q30;
	logic signed [POS_BITS:0]    diff;
	logic                        neg;
	logic [POS_BITS-1:0]         mag;
	logic [UQ_BITS+1:0]          s_raw;
	logic [UQ_BITS-1:0]          s_clamp;
	logic [PROD_BITS:0]          prod6;
	logic signed [SAT_BITS-1:0]  pos_full, vel_full;
	logic [DIVQ_BITS-1:0]        vdiv;
	cti_div_req_t                div_req;
	logic                        div_done;
	logic [DIVQ_BITS-1:0]        div_quo;
	logic                        out_free, out_load;
	cti_out_t                    out_d;

	assign acc_in    = req_valid && req_ready;
	assign req_ready = state_q == S_IDLE;
	assign move_ok   = (req.coord_z > 0) && (req.move_duration != '0);
	assign dur_eff   = (duration_q == '0) ? TIME_BITS'(1) : duration_q;
	assign t_eff     = (sampled_q < dur_eff) ? sampled_q : dur_eff;

	assign diff     = {target_q[axis_q][POS_BITS-1], target_q[axis_q]}
	                - {start_q[axis_q][POS_BITS-1], start_q[axis_q]};
	assign neg      = diff[POS_BITS];
	assign mag      = neg ? POS_BITS'(-diff) : diff[POS_BITS-1:0];
	assign prod_rnd = prod_q + (PROD_BITS'(1) << (FRAC_Q - 1));
	assign prod_q30 = prod_rnd[FRAC_Q +: POS_BITS+1];

	assign s_raw   = ({2'b0, u2_q} << 1) + {2'b0, u2_q} - ({2'b0, prod_q[FRAC_Q +: UQ_BITS]} << 1);
	assign s_clamp = (s_raw > (UQ_BITS+2)'(ONE_Q)) ? ONE_Q : s_raw[UQ_BITS-1:0];
	assign prod6   = ({1'b0, prod_q} << 2) + ({1'b0, prod_q} << 1);

	assign pos_full = neg ? (SAT_BITS'(start_q[axis_q]) - SAT_BITS'(signed'({1'b0, prod_q30})))
	                      : (SAT_BITS'(start_q[axis_q]) + SAT_BITS'(signed'({1'b0, prod_q30})));
	assign vdiv     = DIVQ_BITS'(prod_q30) + DIVQ_BITS'(dur_eff >> 1);
	assign vel_full = neg ? -SAT_BITS'(signed'({1'b0, div_quo}))
	                      : SAT_BITS'(signed'({1'b0, div_quo}));

	cti_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	cti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		div_req  = '0;
		out_load = 1'b0;
		out_d    = '0;
		case (state_q)
			S_IDLE: begin
				if (acc_in && req.mode == MODE_MOVE) begin
					state_d = S_MOVE_RSP;
				end else if (acc_in && req.mode == MODE_PUBLISH) begin
					state_d = S_UDIV_GO;
				end
			end
			S_MOVE_RSP: begin
				out_d.kind     = KIND_MOVE;
				out_d.accepted = move_ok_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_UDIV_GO: begin
				div_req.start    = 1'b1;
				div_req.q_init   = t_eff == dur_eff;
				div_req.rem_init = (t_eff == dur_eff) ? '0 : t_eff;
				div_req.steps    = U_STEPS;
				div_req.divisor  = dur_eff;
				state_d          = S_UDIV;
			end
			S_UDIV: begin
				if (div_done) begin
					state_d = S_M_UU;
				end
			end
			S_M_UU: begin
				mul_a   = MUL_A_BITS'(u_q);
				mul_b   = u_q;
				state_d = S_M_U2U;
			end
			S_M_U2U: begin
				mul_a   = MUL_A_BITS'(prod_q[FRAC_Q +: UQ_BITS]);
				mul_b   = u_q;
				state_d = S_M_W;
			end
			S_M_W: begin
				mul_a   = MUL_A_BITS'(u_q);
				mul_b   = ONE_Q - u_q;
				state_d = S_W_GET;
			end
			S_W_GET: begin
				state_d = S_AX_P;
			end
			S_AX_P: begin
				mul_a   = mag;
				mul_b   = s_q;
				state_d = S_AX_V;
			end
			S_AX_V: begin
				mul_a   = mag;
				mul_b   = w_q;
				state_d = S_AX_VGO;
			end
			S_AX_VGO: begin
				div_req.start    = 1'b1;
				div_req.dividend = vdiv;
				div_req.steps    = V_STEPS;
				div_req.divisor  = dur_eff;
				state_d          = S_AX_VDIV;
			end
			S_AX_VDIV: begin
				if (div_done) begin
					state_d = (axis_q == 2'd2) ? S_PUB_OUT : S_AX_P;
				end
			end
			S_PUB_OUT: begin
				out_d.kind   = KIND_REF;
				out_d.ref_x  = ref_q[0];
				out_d.ref_y  = ref_q[1];
				out_d.ref_z  = ref_q[2];
				out_d.vel_x  = vel_q[0];
				out_d.vel_y  = vel_q[1];
				out_d.vel_z  = vel_q[2];
				out_d.out_qw = orient_q[0];
				out_d.out_qx = orient_q[1];
				out_d.out_qy = orient_q[2];
				out_d.out_qz = orient_q[3];
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= out_load || (rsp_valid_q && !rsp_ready);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			sampled_q   <= '0;
			duration_q  <= TIME_BITS'(1);
			fb_q        <= '{default: '0};
			start_q     <= '{default: '0};
			target_q    <= '{default: '0};
			orient_q[0] <= QUAT_BITS'(16'h7FFF);
			orient_q[1] <= '0;
			orient_q[2] <= '0;
			orient_q[3] <= '0;
		end else if (acc_in) begin
			case (req.mode)
				MODE_TICK: begin
					if (elapsed_q != TIME_MAX) begin
						elapsed_q <= elapsed_q + TIME_BITS'(1);
					end
				end
				MODE_FEEDBACK: begin
					sampled_q   <= (elapsed_q < duration_q) ? elapsed_q : duration_q;
					fb_q[0]     <= req.coord_x;
					fb_q[1]     <= req.coord_y;
					fb_q[2]     <= req.coord_z;
					orient_q[0] <= req.quat_w;
					orient_q[1] <= req.quat_x;
					orient_q[2] <= req.quat_y;
					orient_q[3] <= req.quat_z;
				end
				MODE_MOVE: begin
					if (move_ok) begin
						target_q[0] <= req.coord_x;
						target_q[1] <= req.coord_y;
						target_q[2] <= req.coord_z;
						start_q     <= fb_q;
						duration_q  <= req.move_duration;
						elapsed_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			move_ok_q <= move_ok;
		end
		if (out_load) begin
			rsp_q <= out_d;
		end
		case (state_q)
			S_UDIV: begin
				if (div_done) begin
					u_q <= div_quo[UQ_BITS-1:0];
				end
			end
			S_M_U2U: begin
				u2_q <= prod_q[FRAC_Q +: UQ_BITS];
			end
			S_M_W: begin
				s_q <= s_clamp;
			end
			S_W_GET: begin
				w_q    <= prod6[FRAC_Q +: UQ_BITS];
				axis_q <= 2'd0;
			end
			S_AX_V: begin
				ref_q[axis_q] <= sat_pos(pos_full);
			end
			S_AX_VDIV: begin
				if (div_done) begin
					vel_q[axis_q] <= sat_pos(vel_full);
					axis_q        <= axis_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`CTI_ASSERT(a_div_done_waited, !div_done || state_q == S_UDIV || state_q == S_AX_VDIV, "Divider finished outside a wait state.")
	`CTI_ASSERT(a_duration_nonzero, duration_q != '0, "Stored move duration is zero.")
	`CTI_ASSERT_NEXT(a_tick_counts, acc_in && req.mode == MODE_TICK && elapsed_q != TIME_MAX, elapsed_q == $past(elapsed_q) + TIME_BITS'(1), "Tick did not advance the elapsed counter.")
	`CTI_ASSERT_NEXT(a_load_when_free, out_load, rsp_valid_q && state_q == S_IDLE, "Result load did not produce a valid word.")

endmodule

// ===== verif/tb_cubic_trajectory_interpolator.sv =====
// Self-checking testbench for cubic_trajectory_interpolator: predicts move responses and
// published reference poses from its own state copy and compares them word by word.
// Depends on cti_pkg and the RTL of the block only.
module tb_cubic_trajectory_interpolator import cti_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned ONE = 64'd1 << 30;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	cti_in_t  req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	cti_out_t rsp;

	cubic_trajectory_interpolator i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #4 clk = ~clk;

	cti_out_t expected_words[$];
	int errors = 0;
	int words_sent = 0;
	int moves_taken = 0;
	int moves_refused = 0;
	int poses_published = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	longint unsigned plan_elapsed, plan_sampled, plan_duration;
	longint plan_feedback[3], plan_start[3], plan_target[3];
	logic [15:0] plan_quat[4];

	initial begin
		plan_elapsed = 0;
		plan_sampled = 0;
		plan_duration = 1;
		for (int i = 0; i < 3; i++) begin
			plan_feedback[i] = 0;
			plan_start[i] = 0;
			plan_target[i] = 0;
		end
		plan_quat[0] = 16'h7fff;
		plan_quat[1] = 0;
		plan_quat[2] = 0;
		plan_quat[3] = 0;
	end

	function automatic longint unsigned scale_q30(longint unsigned mag, longint unsigned f);
		return (mag >> 32) * f * 4 + (((mag & 64'hffff_ffff) * f + (ONE >> 1)) >> 30);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	task automatic plan_word(input cti_in_t w);
		cti_out_t e;
		longint c[3];
		longint unsigned tt, tcap, u, u2, u3, s, wv, mag, pm, vm;
		longint d;
		logic [31:0] p[3], v[3];
		c[0] = longint'(w.coord_x);
		c[1] = longint'(w.coord_y);
		c[2] = longint'(w.coord_z);
		e = '0;
		case (w.mode)
			MODE_TICK: begin
				if (plan_elapsed < 64'(TIME_MAX)) plan_elapsed++;
			end
			MODE_FEEDBACK: begin
				plan_sampled = (plan_elapsed < plan_duration) ? plan_elapsed : plan_duration;
				for (int i = 0; i < 3; i++) plan_feedback[i] = c[i];
				plan_quat[0] = w.quat_w;
				plan_quat[1] = w.quat_x;
				plan_quat[2] = w.quat_y;
				plan_quat[3] = w.quat_z;
			end
			MODE_MOVE: begin
				e.kind = KIND_MOVE;
				if (c[2] <= 0 || w.move_duration == 0) begin
					moves_refused++;
				end else begin
					for (int i = 0; i < 3; i++) begin
						plan_target[i] = c[i];
						plan_start[i] = plan_feedback[i];
					end
					plan_duration = w.move_duration;
					plan_elapsed = 0;
					e.accepted = 1'b1;
					moves_taken++;
				end
				expected_words.push_back(e);
			end
			MODE_PUBLISH: begin
				tcap = (plan_duration == 0) ? 1 : plan_duration;
				tt = (plan_sampled < tcap) ? plan_sampled : tcap;
				u = (tt << 30) / tcap;
				u2 = (u * u) >> 30;
				u3 = (u2 * u) >> 30;
				s = 3 * u2 - 2 * u3;
				if (s > ONE) s = ONE;
				wv = (6 * u * (ONE - u)) >> 30;
				for (int i = 0; i < 3; i++) begin
					d = plan_target[i] - plan_start[i];
					mag = (d < 0) ? longint'(-d) : longint'(d);
					pm = scale_q30(mag, s);
					vm = (scale_q30(mag, wv) + (tcap >> 1)) / tcap;
					p[i] = clamp32((d < 0) ? plan_start[i] - longint'(pm)
						: plan_start[i] + longint'(pm));
					v[i] = clamp32((d < 0) ? -longint'(vm) : longint'(vm));
				end
				e.kind = KIND_REF;
				e.ref_x = p[0];
				e.ref_y = p[1];
				e.ref_z = p[2];
				e.vel_x = v[0];
				e.vel_y = v[1];
				e.vel_z = v[2];
				e.out_qw = plan_quat[0];
				e.out_qx = plan_quat[1];
				e.out_qy = plan_quat[2];
				e.out_qz = plan_quat[3];
				poses_published++;
				expected_words.push_back(e);
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_word(input cti_in_t w);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!req_ready);
		plan_word(w);
		words_sent++;
	endtask

	task automatic compare_field(input string name, input longint e, input longint a);
		if (e != a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				cti_out_t e;
				e = expected_words.pop_front();
				compare_field("kind", e.kind, rsp.kind);
				compare_field("accepted", e.accepted, rsp.accepted);
				compare_field("ref_x", e.ref_x, rsp.ref_x);
				compare_field("ref_y", e.ref_y, rsp.ref_y);
				compare_field("ref_z", e.ref_z, rsp.ref_z);
				compare_field("vel_x", e.vel_x, rsp.vel_x);
				compare_field("vel_y", e.vel_y, rsp.vel_y);
				compare_field("vel_z", e.vel_z, rsp.vel_z);
				compare_field("out_qw", e.out_qw, rsp.out_qw);
				compare_field("out_qx", e.out_qx, rsp.out_qx);
				compare_field("out_qy", e.out_qy, rsp.out_qy);
				compare_field("out_qz", e.out_qz, rsp.out_qz);
			end
		end
		rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic cti_in_t random_word(input mode_t m);
		cti_in_t w;
		w.mode = m;
		w.coord_x = $urandom;
		w.coord_y = $urandom;
		w.coord_z = $urandom;
		w.move_duration = 20'($urandom);
		w.quat_w = 16'($urandom);
		w.quat_x = 16'($urandom);
		w.quat_y = 16'($urandom);
		w.quat_z = 16'($urandom);
		return w;
	endfunction

	function automatic cti_in_t make_word(input mode_t m, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z, input logic [19:0] dur);
		cti_in_t w;
		w = random_word(m);
		w.coord_x = x;
		w.coord_y = y;
		w.coord_z = z;
		w.move_duration = dur;
		return w;
	endfunction

	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++) send_word(random_word(MODE_TICK));
	endtask

	task automatic test_corner_words;
		cti_in_t w;
		send_word(random_word(MODE_PUBLISH));
		w = make_word(MODE_FEEDBACK, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 20'h0);
		w.quat_w = 16'sh8000;
		w.quat_x = 16'sh7fff;
		send_word(w);
		send_word(make_word(MODE_MOVE, 32'h10000, 32'h10000, 32'h0, 20'd5));
		send_word(make_word(MODE_MOVE, 32'h10000, 32'h10000, 32'h8000_0000, 20'd5));
		send_word(make_word(MODE_MOVE, 32'h10000, 32'h10000, 32'h10000, 20'h0));
		send_word(make_word(MODE_MOVE, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 20'd2));
		send_word(random_word(MODE_PUBLISH));
		send_ticks(1);
		send_word(make_word(MODE_FEEDBACK, 32'h0, 32'h0, 32'h0, 20'h0));
		send_word(random_word(MODE_PUBLISH));
		send_ticks(2);
		send_word(make_word(MODE_FEEDBACK, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 20'h0));
		send_word(random_word(MODE_PUBLISH));
		send_word(make_word(MODE_MOVE, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 20'hfffff));
		send_ticks(3);
		send_word(random_word(MODE_FEEDBACK));
		send_word(random_word(MODE_PUBLISH));
		send_word(make_word(MODE_MOVE, 32'h50000, 32'hfffb0000, 32'h20000, 20'd20));
		send_ticks(10);
		send_word(random_word(MODE_FEEDBACK));
		send_word(make_word(MODE_MOVE, 32'h1234, 32'h5678, 32'h9abc, 20'd4));
		send_word(random_word(MODE_PUBLISH));
	endtask

	function automatic logic [31:0] near_coord();
		return $signed($urandom) >>> $urandom_range(0, 16);
	endfunction

	task automatic test_trajectories(input int n_words, input int idle, input int stall);
		cti_in_t w;
		int stop_at, dur, k;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			send_word(make_word(MODE_FEEDBACK, near_coord(), near_coord(), near_coord(),
				20'h0));
			dur = ($urandom_range(19) == 0) ? $urandom_range(1, 20'hfffff) : $urandom_range(1, 40);
			w = make_word(MODE_MOVE, near_coord(), near_coord(),
				$urandom_range(1, 32'h7fff_ffff), 20'(dur));
			if ($urandom_range(9) == 0) begin
				if ($urandom_range(1)) w.coord_z = -$signed(32'($urandom_range(0, 32'h7fff_ffff)));
				else w.move_duration = 0;
			end
			send_word(w);
			k = $urandom_range(1, 4);
			repeat (k) begin
				send_ticks($urandom_range(0, (dur > 45) ? 50 : dur + 5));
				send_word(make_word(MODE_FEEDBACK, near_coord(), near_coord(), near_coord(),
					20'h0));
				send_word(random_word(MODE_PUBLISH));
				if ($urandom_range(9) == 0) send_word(random_word(mode_t'($urandom_range(3))));
			end
		end
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_words();
		test_trajectories(400, 0, 0);
		test_trajectories(400, 65, 0);
		test_trajectories(400, 0, 65);
		test_trajectories(400, 20, 20);
		drain();
		$display("Sent %0d words: %0d moves taken, %0d refused, %0d poses published,",
			words_sent, moves_taken, moves_refused, poses_published);
		$display("across phases with no gaps, sender gaps, receiver stalls and both.");
		if (errors == 0) begin
			$display("cubic_trajectory_interpolator verification clean");
		end else begin
			$display("cubic_trajectory_interpolator verification failed");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("cubic_trajectory_interpolator verification failed");
		$finish;
	end
endmodule
